@@ hw/rtl/pdf_pkg.sv @@
package pdf_pkg;

    // Payload and gain formats.
    localparam int DATA_W         = 16;
    localparam int GAIN_W         = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int ALPHA_W        = 8;
    localparam int ALPHA_BITS     = 8;
    localparam int MODE_W         = 2;
    localparam int DEADBAND_W     = 16;
    localparam int ILIM_W         = 31;
    localparam int OLIM_W         = 15;

    // Internal datapath widths.
    localparam int ERR_W    = DATA_W + 1;
    localparam int DIFF1_W  = ERR_W + 1;
    localparam int DIFF2_W  = ERR_W + 2;
    localparam int INTEG_W  = 32;
    localparam int FILT_W   = 32;
    localparam int OPB_W    = 32;
    localparam int PROD_W   = GAIN_W + OPB_W;
    localparam int ACC_W    = PROD_W;
    localparam int DTERM_W  = GAIN_W + DIFF2_W - GAIN_FRAC_BITS;

    // Configuration port.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ILIM     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OLIM     = 3'd7;

    // Mode codes; any other code disables the controller.
    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_VEL = 2'd2;

    localparam logic [OLIM_W-1:0] OLIM_RESET = {OLIM_W{1'b1}};

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [ALPHA_W-1:0]       filter_alpha;
        logic [DEADBAND_W-1:0]    deadband;
        logic [ILIM_W-1:0]        integral_limit;
        logic [OLIM_W-1:0]        output_limit;
    } cfg_t;

    // Operand pair fed to the shared multiplier.
    typedef enum logic [2:0] {
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_FX,
        MUL_FY
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     check;
        logic     integ;
        logic     acc_init;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_add_prod;
        logic     dterm_load;
        logic     filt_sum;
        logic     filt_upd;
        logic     acc_add_filt;
        logic     sat;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic enabled;
        logic positional;
        logic in_deadband;
        logic alpha_zero;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MP,
        S_MI,
        S_MD,
        S_DT,
        S_FX,
        S_FY,
        S_FS,
        S_FA,
        S_SAT,
        S_DONE
    } state_t;

endpackage

@@ hw/rtl/pdf_if.sv @@
// One control tick: setpoint and measured value.
interface pdf_sample_if;
    import pdf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measure;

    modport source (output valid, output target, output measure, input ready);
    modport sink (input valid, input target, input measure, output ready);
endinterface

// One controller result: drive value and deadband flag.
interface pdf_result_if;
    import pdf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;
    logic                     held;

    modport source (output valid, output drive, output held, input ready);
    modport sink (input valid, input drive, input held, output ready);
endinterface

@@ hw/rtl/pid_dual_form_deadband_filtered.sv @@
// PID controller with positional and incremental (velocity) forms, a deadband on the
// error, a clamped integral, an optional first-order low-pass on the derivative term
// and symmetric output saturation. Each transfer on the sample channel carries a
// target and a measurement and produces exactly one transfer on the result channel
// with the saturated drive and a held flag that is set when the error fell inside the
// deadband and the previous drive was repeated. Gains are signed Q8.8, alpha is in
// 1/256 units. The registers are to be written over the APB port while the block is
// idle; the user must keep to this, as the block does not enforce it. A held tick or
// a disabled mode skips the multiplier; otherwise the single shared 16x32 multiplier
// forms the P, I, D and, if alpha is nonzero, filter products one per cycle.
// A result waiting in the output register does not block the next sample.
module pid_dual_form_deadband_filtered (
    input  logic                            clk,
    input  logic                            rst_n,
    pdf_sample_if.sink                      sample,
    pdf_result_if.source                    result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pdf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pdf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import pdf_pkg::*;

    cfg_t                     cfg;
    dp_cmd_t                  cmd;
    dp_status_t               status;
    logic                     in_ready;
    logic                     out_valid;
    logic signed [DATA_W-1:0] drive;
    logic                     held;

    // Configuration registers.
    pdf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    pdf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and controller state.
    pdf_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cmd     (cmd),
        .status  (status),
        .target  (sample.target),
        .measure (sample.measure),
        .drive   (drive),
        .held    (held)
    );

    assign sample.ready = in_ready;
    assign result.valid = out_valid;
    assign result.drive = drive;
    assign result.held  = held;

endmodule

@@ hw/rtl/pdf_cfg.sv @@
module pdf_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pdf_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [pdf_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [pdf_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output pdf_pkg::cfg_t                   cfg
);
    import pdf_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MODE:     cfg_next.mode           = pwdata[MODE_W-1:0];
                REG_GAIN_P:   cfg_next.gain_p         = $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_I:   cfg_next.gain_i         = $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_D:   cfg_next.gain_d         = $signed(pwdata[GAIN_W-1:0]);
                REG_ALPHA:    cfg_next.filter_alpha   = pwdata[ALPHA_W-1:0];
                REG_DEADBAND: cfg_next.deadband       = pwdata[DEADBAND_W-1:0];
                REG_ILIM:     cfg_next.integral_limit = pwdata[ILIM_W-1:0];
                REG_OLIM:     cfg_next.output_limit   = pwdata[OLIM_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg              <= '0;
            cfg_reg.output_limit <= OLIM_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (idx)
            REG_MODE:     prdata = CFG_DATA_W'(cfg_reg.mode);
            REG_GAIN_P:   prdata = CFG_DATA_W'(unsigned'(cfg_reg.gain_p));
            REG_GAIN_I:   prdata = CFG_DATA_W'(unsigned'(cfg_reg.gain_i));
            REG_GAIN_D:   prdata = CFG_DATA_W'(unsigned'(cfg_reg.gain_d));
            REG_ALPHA:    prdata = CFG_DATA_W'(cfg_reg.filter_alpha);
            REG_DEADBAND: prdata = CFG_DATA_W'(cfg_reg.deadband);
            REG_ILIM:     prdata = CFG_DATA_W'(cfg_reg.integral_limit);
            REG_OLIM:     prdata = CFG_DATA_W'(cfg_reg.output_limit);
            default:      prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/pdf_dp.sv @@
module pdf_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pdf_pkg::cfg_t                     cfg,
    input  pdf_pkg::dp_cmd_t                  cmd,
    output pdf_pkg::dp_status_t               status,
    input  logic signed [pdf_pkg::DATA_W-1:0] target,
    input  logic signed [pdf_pkg::DATA_W-1:0] measure,
    output logic signed [pdf_pkg::DATA_W-1:0] drive,
    output logic                              held
);
    import pdf_pkg::*;

    // Controller state that persists across ticks.
    logic signed [ERR_W-1:0]   err_now_reg;
    logic signed [ERR_W-1:0]   err_prev_reg;
    logic signed [ERR_W-1:0]   err_older_reg;
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [INTEG_W-1:0] integral_next;
    logic signed [FILT_W-1:0]  filt_reg;
    logic signed [FILT_W-1:0]  filt_next;
    logic signed [DATA_W-1:0]  drive_reg;
    logic signed [DATA_W-1:0]  drive_next;
    logic                      held_reg;

    // Working registers for one tick.
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [DTERM_W-1:0] dterm_reg;
    logic signed [ACC_W-1:0]   fsum_reg;
    logic signed [DATA_W-1:0]  out_drive_reg;
    logic                      out_held_reg;

    logic signed [ERR_W-1:0]   err_new;
    logic [ERR_W-1:0]          err_mag;
    logic signed [DIFF1_W-1:0] diff1;
    logic signed [DIFF2_W-1:0] diff2;
    logic signed [INTEG_W:0]   integ_sum;
    logic signed [INTEG_W:0]   ilim;
    logic signed [GAIN_W-1:0]  op_a;
    logic signed [OPB_W-1:0]   op_b;
    logic [ALPHA_BITS:0]       alpha_comp;
    logic signed [PROD_W-1:0]  prod_scaled;
    logic signed [ACC_W-1:0]   fsum_all;
    logic signed [ACC_W-1:0]   filt_shift;
    logic signed [ACC_W-1:0]   filt_max;
    logic signed [ACC_W-1:0]   olim;

    // Status toward the controller.
    assign status.enabled     = (cfg.mode == MODE_POS) || (cfg.mode == MODE_VEL);
    assign status.positional  = (cfg.mode == MODE_POS);
    assign err_mag            = err_now_reg[ERR_W-1] ? ERR_W'(-err_now_reg)
                                                     : ERR_W'(err_now_reg);
    assign status.in_deadband = err_mag < ERR_W'(cfg.deadband);
    assign status.alpha_zero  = (cfg.filter_alpha == '0);

    // Error and its first and second differences.
    assign err_new = ERR_W'(target) - ERR_W'(measure);
    assign diff1   = DIFF1_W'(err_now_reg) - DIFF1_W'(err_prev_reg);
    assign diff2   = DIFF2_W'(err_now_reg) - (DIFF2_W'(err_prev_reg) <<< 1)
                   + DIFF2_W'(err_older_reg);

    // Integral accumulate with symmetric clamp.
    assign integ_sum = (INTEG_W+1)'(integral_reg) + (INTEG_W+1)'(err_now_reg);
    assign ilim      = (INTEG_W+1)'($signed({1'b0, cfg.integral_limit}));

    always_comb
    begin
        if (cfg.gain_i == '0)
            integral_next = '0;
        else if (integ_sum > ilim)
            integral_next = INTEG_W'(ilim);
        else if (integ_sum < -ilim)
            integral_next = INTEG_W'(-ilim);
        else
            integral_next = INTEG_W'(integ_sum);
    end

    // Operand selection for the shared multiplier.
    assign alpha_comp = (ALPHA_BITS+1)'(1 << ALPHA_BITS) - (ALPHA_BITS+1)'(cfg.filter_alpha);

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_P:
            begin
                op_a = cfg.gain_p;
                op_b = status.positional ? OPB_W'(err_now_reg) : OPB_W'(diff1);
            end
            MUL_I:
            begin
                op_a = cfg.gain_i;
                op_b = status.positional ? OPB_W'(integral_reg) : OPB_W'(err_now_reg);
            end
            MUL_D:
            begin
                op_a = cfg.gain_d;
                op_b = status.positional ? OPB_W'(diff1) : OPB_W'(diff2);
            end
            MUL_FX:
            begin
                op_a = GAIN_W'($signed({1'b0, cfg.filter_alpha}));
                op_b = OPB_W'(dterm_reg);
            end
            MUL_FY:
            begin
                op_a = GAIN_W'($signed({1'b0, alpha_comp}));
                op_b = OPB_W'(filt_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next   = op_a * op_b;
    assign prod_scaled = prod_reg >>> GAIN_FRAC_BITS;

    // Derivative low-pass: weighted sum, floor shift, clamp to 32 bits.
    assign fsum_all   = fsum_reg + ACC_W'(prod_reg);
    assign filt_shift = fsum_all >>> ALPHA_BITS;
    assign filt_max   = ACC_W'($signed({1'b0, {(FILT_W-1){1'b1}}}));

    always_comb
    begin
        if (filt_shift > filt_max)
            filt_next = FILT_W'(filt_max);
        else if (filt_shift < -filt_max)
            filt_next = FILT_W'(-filt_max);
        else
            filt_next = FILT_W'(filt_shift);
    end

    // Output saturation.
    assign olim = ACC_W'($signed({1'b0, cfg.output_limit}));

    always_comb
    begin
        if (acc_reg > olim)
            drive_next = DATA_W'(olim);
        else if (acc_reg < -olim)
            drive_next = DATA_W'(-olim);
        else
            drive_next = DATA_W'(acc_reg);
    end

    // Persistent controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_now_reg   <= '0;
            err_prev_reg  <= '0;
            err_older_reg <= '0;
            integral_reg  <= '0;
            filt_reg      <= '0;
            drive_reg     <= '0;
            held_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (status.enabled)
                begin
                    err_older_reg <= err_prev_reg;
                    err_prev_reg  <= err_now_reg;
                    err_now_reg   <= err_new;
                end
                else
                begin
                    err_older_reg <= '0;
                    err_prev_reg  <= '0;
                    err_now_reg   <= '0;
                    integral_reg  <= '0;
                    drive_reg     <= '0;
                end
            end
            if (cmd.check)
                held_reg <= status.enabled && status.in_deadband;
            if (cmd.integ)
                integral_reg <= integral_next;
            if (cmd.filt_upd)
                filt_reg <= filt_next;
            if (cmd.sat)
                drive_reg <= drive_next;
        end
    end

    // Per-tick working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.acc_init)
            acc_reg <= status.positional ? '0 : ACC_W'(drive_reg);
        else if (cmd.acc_add_prod)
            acc_reg <= acc_reg + ACC_W'(prod_scaled);
        else if (cmd.acc_add_filt)
            acc_reg <= acc_reg + ACC_W'(filt_reg);
        if (cmd.dterm_load)
            dterm_reg <= DTERM_W'(prod_scaled);
        if (cmd.filt_sum)
            fsum_reg <= ACC_W'(prod_reg);
        if (cmd.out_load)
        begin
            out_drive_reg <= drive_reg;
            out_held_reg  <= held_reg;
        end
    end

    assign drive = out_drive_reg;
    assign held  = out_held_reg;

`ifndef SYNTHESIS
    // The clamped integral stays within the configured limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.integ |=> ((INTEG_W+1)'(integral_reg) <= ilim)
                   && ((INTEG_W+1)'(integral_reg) >= -ilim))
        else $error("integral outside its limit after update");

    // A saturated drive stays within the output limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sat |=> (ACC_W'(drive_reg) <= olim) && (ACC_W'(drive_reg) >= -olim))
        else $error("drive outside output limit after saturation");

    // A tick in disabled mode clears the history, integral and drive.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && !status.enabled) |=> (drive_reg == '0) && (integral_reg == '0)
                                         && (err_now_reg == '0) && (err_prev_reg == '0))
        else $error("disabled tick did not clear controller state");
`endif

endmodule

@@ hw/rtl/pdf_ctrl.sv @@
module pdf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pdf_pkg::dp_status_t status,
    output pdf_pkg::dp_cmd_t    cmd
);
    import pdf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequencer: an updating tick runs through the shared multiplier step by step.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (!status.enabled || status.in_deadband)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.integ    = status.positional;
                    cmd.acc_init = 1'b1;
                    state_next   = S_MP;
                end
            end
            S_MP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_P;
                state_next  = S_MI;
            end
            S_MI:
            begin
                cmd.mul_en       = 1'b1;
                cmd.mul_sel      = MUL_I;
                cmd.acc_add_prod = 1'b1;
                state_next       = S_MD;
            end
            S_MD:
            begin
                cmd.mul_en       = 1'b1;
                cmd.mul_sel      = MUL_D;
                cmd.acc_add_prod = 1'b1;
                state_next       = S_DT;
            end
            S_DT:
            begin
                cmd.dterm_load = 1'b1;
                if (status.alpha_zero)
                begin
                    cmd.acc_add_prod = 1'b1;
                    state_next       = S_SAT;
                end
                else
                begin
                    state_next = S_FX;
                end
            end
            S_FX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FX;
                state_next  = S_FY;
            end
            S_FY:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_FY;
                cmd.filt_sum = 1'b1;
                state_next   = S_FS;
            end
            S_FS:
            begin
                cmd.filt_upd = 1'b1;
                state_next   = S_FA;
            end
            S_FA:
            begin
                cmd.acc_add_filt = 1'b1;
                state_next       = S_SAT;
            end
            S_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Wait for the output register to free up.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register valid flag.
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // A new result is never loaded over one that has not been transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before transfer");

    // An accepted tick always starts with the deadband check.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_CHECK))
        else $error("accepted tick did not enter the check step");

    // The filter state only moves when the filter is switched on.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.filt_upd |-> !status.alpha_zero)
        else $error("filter state updated with filter disabled");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pdf_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          LONG_STALL     = 300;
    localparam int          SETTLE_CYCLES  = 16;
    localparam logic [1:0]  MODE_SPARE     = 2'd3;

    typedef struct {
        logic signed [DATA_W-1:0] target;
        logic signed [DATA_W-1:0] measure;
    } tick_t;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic                     held;
    } drive_res_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     s_valid   = 1'b0;
    logic signed [DATA_W-1:0] s_target  = '0;
    logic signed [DATA_W-1:0] s_measure = '0;
    logic                     r_ready   = 1'b0;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0]    paddr     = '0;
    logic [CFG_DATA_W-1:0]    pwdata    = '0;
    logic [CFG_DATA_W-1:0]    prdata;
    logic                     pready;

    pdf_sample_if smp ();
    pdf_result_if res ();

    assign smp.valid   = s_valid;
    assign smp.target  = s_target;
    assign smp.measure = s_measure;
    assign res.ready   = r_ready;

    pid_dual_form_deadband_filtered u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp),
        .result  (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 clk = ~clk;

    // Register copies as the controller should see them.
    logic [MODE_W-1:0]        sh_mode     = MODE_OFF;
    logic signed [GAIN_W-1:0] sh_kp       = '0;
    logic signed [GAIN_W-1:0] sh_ki       = '0;
    logic signed [GAIN_W-1:0] sh_kd       = '0;
    logic [ALPHA_W-1:0]       sh_alpha    = '0;
    logic [DEADBAND_W-1:0]    sh_deadband = '0;
    logic [ILIM_W-1:0]        sh_ilim     = '0;
    logic [OLIM_W-1:0]        sh_olim     = OLIM_RESET;

    // Controller state tracked by the predictor.
    logic signed [ERR_W-1:0]   st_err0  = '0;
    logic signed [ERR_W-1:0]   st_err1  = '0;
    logic signed [ERR_W-1:0]   st_err2  = '0;
    logic signed [INTEG_W-1:0] st_integ = '0;
    logic signed [FILT_W-1:0]  st_filt  = '0;
    logic signed [DATA_W-1:0]  st_drive = '0;

    tick_t       tick_q[$];
    drive_res_t  drive_expect_q[$];
    int          queued_cnt   = 0;
    int          accepted_cnt = 0;
    int          mismatch_cnt = 0;
    int          idle_cycles  = 0;
    int unsigned gap_cnt      = 0;
    int unsigned hold_cnt     = 0;
    logic        in_xfer      = 1'b0;
    logic        steady_phase = 1'b0;
    logic        stall_armed  = 1'b0;
    logic        stall_done   = 1'b0;

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    // First-order low-pass on the derivative term; alpha of zero bypasses it.
    function automatic longint smooth_deriv(input longint x);
        longint al;
        longint y;
        if (sh_alpha == 0)
            return x;
        al = longint'(sh_alpha);
        y = (al * x + ((longint'(1) <<< ALPHA_BITS) - al) * longint'(st_filt)) >>> ALPHA_BITS;
        st_filt = FILT_W'(clamp_sym(y, 64'sd2147483647));
        return longint'(st_filt);
    endfunction

    // Work out the drive for one control tick and advance the state.
    function automatic void predict_tick(input logic signed [DATA_W-1:0] tgt,
                                         input logic signed [DATA_W-1:0] meas,
                                         output drive_res_t res_o);
        longint e0;
        longint e1;
        longint e2;
        longint mag;
        longint p_term;
        longint i_term;
        longint d_term;
        longint sum;
        res_o.held = 1'b0;
        if (sh_mode != MODE_POS && sh_mode != MODE_VEL)
        begin
            st_err0    = '0;
            st_err1    = '0;
            st_err2    = '0;
            st_integ   = '0;
            st_drive   = '0;
            res_o.drive = '0;
            return;
        end
        e0 = longint'(tgt) - longint'(meas);
        st_err2 = st_err1;
        st_err1 = st_err0;
        st_err0 = ERR_W'(e0);
        e1 = st_err1;
        e2 = st_err2;
        mag = (e0 < 0) ? -e0 : e0;
        if (mag >= longint'(sh_deadband))
        begin
            if (sh_mode == MODE_POS)
            begin
                if (sh_ki != 0)
                    st_integ = INTEG_W'(clamp_sym(longint'(st_integ) + e0, longint'(sh_ilim)));
                else
                    st_integ = '0;
                p_term = (longint'(sh_kp) * e0) >>> GAIN_FRAC_BITS;
                i_term = (longint'(sh_ki) * longint'(st_integ)) >>> GAIN_FRAC_BITS;
                d_term = smooth_deriv((longint'(sh_kd) * (e0 - e1)) >>> GAIN_FRAC_BITS);
                sum = p_term + i_term + d_term;
            end
            else
            begin
                p_term = (longint'(sh_kp) * (e0 - e1)) >>> GAIN_FRAC_BITS;
                i_term = (longint'(sh_ki) * e0) >>> GAIN_FRAC_BITS;
                d_term = smooth_deriv((longint'(sh_kd) * (e0 - 2 * e1 + e2)) >>> GAIN_FRAC_BITS);
                sum = longint'(st_drive) + p_term + i_term + d_term;
            end
            st_drive = DATA_W'(clamp_sym(sum, longint'(sh_olim)));
        end
        else
        begin
            res_o.held = 1'b1;
        end
        res_o.drive = st_drive;
    endfunction

    function automatic void mirror_register(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_MODE:     sh_mode     = value[MODE_W-1:0];
            REG_GAIN_P:   sh_kp       = value[GAIN_W-1:0];
            REG_GAIN_I:   sh_ki       = value[GAIN_W-1:0];
            REG_GAIN_D:   sh_kd       = value[GAIN_W-1:0];
            REG_ALPHA:    sh_alpha    = value[ALPHA_W-1:0];
            REG_DEADBAND: sh_deadband = value[DEADBAND_W-1:0];
            REG_ILIM:     sh_ilim     = value[ILIM_W-1:0];
            REG_OLIM:     sh_olim     = value[OLIM_W-1:0];
            default:      ;
        endcase
    endfunction

    // Mostly back to back, sometimes a short pause, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int unsigned r;
        r = $urandom_range(0, 11);
        if (r == 0)
            return '0;
        if (r == 1)
            return 16'h8000;
        if (r == 2)
            return 16'h7FFF;
        if (r < 8)
            return GAIN_W'($urandom_range(0, 1023)) - 16'd512;
        return GAIN_W'($urandom);
    endfunction

    // Register write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        mirror_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_controller(input logic [MODE_W-1:0] md, input logic [GAIN_W-1:0] kp,
                                  input logic [GAIN_W-1:0] ki, input logic [GAIN_W-1:0] kd,
                                  input logic [ALPHA_W-1:0] al, input logic [DEADBAND_W-1:0] db,
                                  input logic [ILIM_W-1:0] il, input logic [OLIM_W-1:0] ol);
        apb_write(REG_MODE, CFG_DATA_W'(md));
        apb_write(REG_GAIN_P, CFG_DATA_W'(kp));
        apb_write(REG_GAIN_I, CFG_DATA_W'(ki));
        apb_write(REG_GAIN_D, CFG_DATA_W'(kd));
        apb_write(REG_ALPHA, CFG_DATA_W'(al));
        apb_write(REG_DEADBAND, CFG_DATA_W'(db));
        apb_write(REG_ILIM, CFG_DATA_W'(il));
        apb_write(REG_OLIM, CFG_DATA_W'(ol));
    endtask

    task automatic push_tick(input int tgt, input int meas);
        tick_t t;
        t.target  = DATA_W'(tgt);
        t.measure = DATA_W'(meas);
        tick_q.push_back(t);
        queued_cnt++;
    endtask

    // Wait until every tick has come back, then let the block settle.
    task automatic drain();
        while (accepted_cnt != queued_cnt || drive_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Random settings, extremes included now and then.
    task automatic rand_config();
        int unsigned         r;
        logic [MODE_W-1:0]   md;
        logic [ALPHA_W-1:0]  al;
        logic [DEADBAND_W-1:0] db;
        logic [ILIM_W-1:0]   il;
        logic [OLIM_W-1:0]   ol;
        r  = $urandom_range(0, 9);
        md = (r < 4) ? MODE_POS : (r < 8) ? MODE_VEL : (r == 8) ? MODE_OFF : MODE_SPARE;
        r  = $urandom_range(0, 3);
        al = (r == 0) ? '0 : (r == 1) ? 8'hFF : ALPHA_W'($urandom_range(1, 254));
        r  = $urandom_range(0, 5);
        db = (r < 2) ? '0 : (r == 2) ? 16'hFFFF :
             (r < 5) ? DEADBAND_W'($urandom_range(0, 300)) : DEADBAND_W'($urandom);
        r  = $urandom_range(0, 4);
        il = (r == 0) ? '0 : (r == 1) ? 31'h7FFF_FFFF :
             (r < 4) ? ILIM_W'($urandom_range(0, 200000)) : ILIM_W'($urandom);
        r  = $urandom_range(0, 4);
        ol = (r == 0) ? '0 : (r == 1) ? 15'h7FFF : OLIM_W'($urandom);
        set_controller(md, pick_gain(), pick_gain(), pick_gain(), al, db, il, ol);
    endtask

    // Errors spread over the whole range, near the deadband, or at the rails.
    task automatic push_rand_tick();
        int unsigned r;
        int          tv;
        int          mv;
        int          span;
        r  = $urandom_range(0, 9);
        tv = int'($urandom_range(0, 65535)) - 32768;
        if (r < 4)
        begin
            mv = int'($urandom_range(0, 65535)) - 32768;
        end
        else if (r < 9)
        begin
            span = int'(sh_deadband) + (int'(sh_deadband) >> 1) + 64;
            if (span > 65535)
                span = 65535;
            mv = tv + int'($urandom_range(0, 2 * span)) - span;
            if (mv > 32767)
                mv = 32767;
            if (mv < -32768)
                mv = -32768;
        end
        else
        begin
            tv = $urandom_range(0, 1) ? 32767 : -32768;
            mv = $urandom_range(0, 1) ? 32767 : -32768;
        end
        push_tick(tv, mv);
    endtask

    // Sample driver: holds a transfer until accepted, then pauses or moves on.
    always @(negedge clk)
    begin : tick_driver
        tick_t nxt;
        if (rst_n && (!s_valid || in_xfer))
        begin
            if (gap_cnt != 0)
            begin
                s_valid <= 1'b0;
                gap_cnt <= gap_cnt - 1;
            end
            else if (tick_q.size() != 0)
            begin
                nxt = tick_q.pop_front();
                s_valid   <= 1'b1;
                s_target  <= nxt.target;
                s_measure <= nxt.measure;
                gap_cnt   <= pick_gap();
            end
            else
            begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result backpressure, including one long hold-off when armed.
    always @(negedge clk)
    begin : result_ready
        if (rst_n)
        begin
            if (hold_cnt != 0)
            begin
                r_ready  <= 1'b0;
                hold_cnt <= hold_cnt - 1;
            end
            else if (stall_armed && !stall_done)
            begin
                r_ready    <= 1'b0;
                hold_cnt   <= LONG_STALL;
                stall_done <= 1'b1;
            end
            else if (!steady_phase && $urandom_range(0, 3) == 0)
            begin
                r_ready  <= 1'b0;
                hold_cnt <= pick_gap();
            end
            else
            begin
                r_ready <= 1'b1;
            end
        end
    end

    // Predict on each accepted sample, compare each accepted result.
    always @(posedge clk)
    begin : result_check
        drive_res_t predicted;
        drive_res_t want;
        if (rst_n)
        begin
            in_xfer <= s_valid && smp.ready;
            if (s_valid && smp.ready)
            begin
                predict_tick(s_target, s_measure, predicted);
                drive_expect_q.push_back(predicted);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (res.valid && r_ready)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    $error("unexpected result transfer: drive %0d held %0b", res.drive, res.held);
                    mismatch_cnt++;
                end
                else
                begin
                    want = drive_expect_q.pop_front();
                    if (res.drive !== want.drive)
                    begin
                        $error("drive: expected %0d, got %0d", want.drive, res.drive);
                        mismatch_cnt++;
                    end
                    if (res.held !== want.held)
                    begin
                        $error("held: expected %0b, got %0b", want.held, res.held);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((s_valid && smp.ready) || (res.valid && r_ready) || (psel && penable && pready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // Disabled after reset: output stays zero.
        push_tick(32767, -32768);
        push_tick(-32768, 32767);
        drain();

        // Positional, unity P, zero I gain clears the integral; largest errors.
        set_controller(MODE_POS, 16'sd256, '0, '0, '0, '0, 31'd1000, 15'h7FFF);
        push_tick(32767, -32768);
        push_tick(-32768, 32767);
        push_tick(0, 0);
        drain();

        // Positional with filter: inside, at and beyond the deadband; both clamps.
        set_controller(MODE_POS, 16'sd128, 16'sd64, 16'sd200, 8'd128, 16'd100, 31'd500,
                       15'd1000);
        push_tick(50, 0);
        push_tick(100, 0);
        push_tick(0, -100);
        push_tick(-32768, 32767);
        push_tick(32767, -32768);
        drain();

        // Velocity form with extreme gains, full alpha, widest limits.
        set_controller(MODE_VEL, 16'h8000, 16'h7FFF, 16'h7FFF, 8'hFF, '0, 31'h7FFF_FFFF,
                       15'h7FFF);
        push_tick(1000, 0);
        push_tick(32767, -32768);
        push_tick(-32768, 32767);
        push_tick(0, 0);
        drain();

        // Widest deadband with a lowered output limit: the old drive is repeated.
        set_controller(MODE_VEL, '0, '0, '0, '0, 16'hFFFF, '0, 15'd5);
        push_tick(10, 0);
        push_tick(0, 300);
        drain();

        // The spare mode code behaves as disabled.
        set_controller(MODE_SPARE, 16'sd256, 16'sd256, 16'sd256, '0, '0, 31'd1000, 15'h7FFF);
        push_tick(123, -45);
        push_tick(-1, 1);
        drain();

        // Random settings and ticks; one phase holds the result side off for long.
        for (int ph = 0; ph < 12; ph++)
        begin
            steady_phase = (ph == 4 || ph == 9);
            if (ph == 2)
                stall_armed = 1'b1;
            rand_config();
            for (int k = 0; k < 50; k++)
                push_rand_tick();
            drain();
        end

        if (mismatch_cnt == 0 && drive_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
